// ===== rtl/core/zmp4_pkg.sv =====
// ---------------------------------------------------------------------------
// zmp4_pkg: shared types and constants
// payload structs, register map, queue status and divider helpers for the
// four load cell zero moment point block
// ---------------------------------------------------------------------------
package zmp4_pkg;

  // default fraction bits of moments, force and zmp
  localparam int FracBitsDef = 16;

  // register reset values (gains are unsigned q8.f)
  localparam logic [23:0] GainAReset = 24'd2032;
  localparam logic [23:0] GainBReset = 24'd1966;
  localparam logic [23:0] GainFReset = 24'd111740;

  localparam int AddrW = 4;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 3);

  // quotient bits produced by each divider lane
  localparam int DivSteps = 34;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    REG_GAIN_A  = 2'd0,
    REG_GAIN_B  = 2'd1,
    REG_GAIN_F  = 2'd2,
    REG_REVERSE = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_st_e;

  typedef struct packed {
    logic signed [23:0] load_0;
    logic signed [23:0] load_1;
    logic signed [23:0] load_2;
    logic signed [23:0] load_3;
  } load_t;

  typedef struct packed {
    logic signed [47:0] moment_a;
    logic signed [47:0] moment_b;
    logic signed [47:0] vertical_force;
    logic signed [31:0] zmp_x;
    logic signed [31:0] zmp_y;
    logic               zmp_valid;
  } result_t;

  typedef struct packed {
    logic [23:0] gain_a;
    logic [23:0] gain_b;
    logic [23:0] gain_f;
    logic        reverse;
  } cfg_t;

  // one classified item waiting for the divider
  typedef struct packed {
    logic signed [47:0] ma;
    logic signed [47:0] mb;
    logic signed [47:0] fz;
    logic               ok;
  } entry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
  } q_stat_t;

  // clamp a 51 bit signed value into 48 bits
  function automatic logic signed [47:0] sat48(logic signed [50:0] v);
    logic signed [47:0] r;
    if (v[50:47] == 4'b0000 || v[50:47] == 4'b1111) begin
      r = v[47:0];
    end else if (v[50]) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  // apply sign and 32 bit saturation to a magnitude quotient
  function automatic logic signed [31:0] zmp_fin(logic [DivSteps-1:0] q, logic ovf,
                                                 logic neg);
    logic [31:0] r;
    if (neg) begin
      if (ovf || q > DivSteps'(34'h0_8000_0000)) begin
        r = 32'h8000_0000;
      end else begin
        r = -q[31:0];
      end
    end else begin
      if (ovf || q > DivSteps'(34'h0_7FFF_FFFF)) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = q[31:0];
      end
    end
    return $signed(r);
  endfunction

endpackage

// ===== rtl/core/zmp4_regs.sv =====
// ---------------------------------------------------------------------------
// zmp4_regs: configuration registers
// apb slave holding the three gains and the reverse flag
// ---------------------------------------------------------------------------
module zmp4_regs import zmp4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_A:  cfg_d.gain_a  = pwdata[23:0];
        REG_GAIN_B:  cfg_d.gain_b  = pwdata[23:0];
        REG_GAIN_F:  cfg_d.gain_f  = pwdata[23:0];
        REG_REVERSE: cfg_d.reverse = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_A:  prdata = {8'd0, cfg_q.gain_a};
      REG_GAIN_B:  prdata = {8'd0, cfg_q.gain_b};
      REG_GAIN_F:  prdata = {8'd0, cfg_q.gain_f};
      REG_REVERSE: prdata = {31'd0, cfg_q.reverse};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gain_a: GainAReset, gain_b: GainBReset, gain_f: GainFReset,
                 reverse: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/zmp4_front.sv =====
// ---------------------------------------------------------------------------
// zmp4_front: accept, scale and classify
// differences and sum, three gain products, sign, saturation and force check
// ---------------------------------------------------------------------------
module zmp4_front import zmp4_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  load_t   load_i,
  input  cfg_t    cfg_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output entry_t  entry_o
);

  localparam logic [47:0] OneVal = 48'(1) << FracBits;

  // stage a: differences and sum
  logic               va_q;
  logic signed [24:0] da_q, db_q;
  logic signed [25:0] sum_q;
  // stage b: products
  logic               vb_q;
  logic signed [49:0] pa_q, pb_q;
  logic signed [50:0] pf_q;

  logic               accept;
  logic [QCntW-1:0]   credit;
  logic signed [50:0] na, nb;
  logic signed [47:0] fz;

  // every item in flight already owns a queue slot
  assign credit = q_stat_i.count + {{(QCntW-1){1'b0}}, va_q} + {{(QCntW-1){1'b0}}, vb_q};
  assign busy   = credit >= QCntW'(QDepth);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= accept;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      da_q  <= 25'(load_i.load_0) - 25'(load_i.load_3);
      db_q  <= 25'(load_i.load_1) - 25'(load_i.load_2);
      sum_q <= 26'(load_i.load_0) + 26'(load_i.load_1) + 26'(load_i.load_2)
             + 26'(load_i.load_3);
    end
    if (va_q) begin
      pa_q <= $signed({1'b0, cfg_i.gain_a}) * da_q;
      pb_q <= $signed({1'b0, cfg_i.gain_b}) * db_q;
      pf_q <= $signed({1'b0, cfg_i.gain_f}) * sum_q;
    end
  end

  // negation on the full product, so it never wraps
  always_comb begin
    na = 51'(pa_q);
    nb = 51'(pb_q);
    if (cfg_i.reverse) begin
      na = -na;
      nb = -nb;
    end
  end

  assign fz       = sat48(pf_q);
  assign push_o   = vb_q;
  assign entry_o.ma = sat48(na);
  assign entry_o.mb = sat48(nb);
  assign entry_o.fz = fz;
  assign entry_o.ok = !fz[47] && ($unsigned(fz) >= OneVal);

endmodule

// ===== rtl/core/zmp4_queue.sv =====
// ---------------------------------------------------------------------------
// zmp4_queue: item queue
// small fifo between the scaling front and the divider back
// ---------------------------------------------------------------------------
module zmp4_queue import zmp4_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  wdata_i,
  input  logic    pop_i,
  output entry_t  rdata_o,
  output q_stat_t stat_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {{(QCntW-1){1'b0}}, push_i} - {{(QCntW-1){1'b0}}, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/zmp4_back.sv =====
// ---------------------------------------------------------------------------
// zmp4_back: zmp divider
// two restoring divider lanes, one quotient bit per cycle, and result register
// ---------------------------------------------------------------------------
module zmp4_back import zmp4_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t q_stat_i,
  input  entry_t  entry_i,
  output logic    pop_o,
  output logic    done_o,
  output result_t result_o
);

  localparam int NExtW = 48 + FracBits;

  back_st_e             state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [47:0]          d_q, d_d;
  entry_t               hold_q, hold_d;
  logic [47:0]          rem_q [2];
  logic [47:0]          rem_d [2];
  logic [DivSteps-1:0]  low_q [2];
  logic [DivSteps-1:0]  low_d [2];
  logic [DivSteps-1:0]  quo_q [2];
  logic [DivSteps-1:0]  quo_d [2];
  logic [1:0]           ovf_q, ovf_d, neg_q, neg_d;
  result_t              res_q, res_d;
  logic                 done_q, done_d;

  // lane step
  logic [48:0]          t_w    [2];
  logic [48:0]          diff_w [2];
  logic [1:0]           ge_w;
  logic [47:0]          rem_n  [2];
  logic [DivSteps-1:0]  quo_n  [2];
  // lane load
  logic signed [47:0]   num_w  [2];
  logic [47:0]          mag_w  [2];
  logic [NExtW-1:0]     next_w [2];
  logic [NExtW-1:0]     hi_w   [2];
  logic [1:0]           ovf0, neg0;

  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t_w[i]    = {rem_q[i], low_q[i][DivSteps-1]};
      diff_w[i] = t_w[i] - {1'b0, d_q};
      ge_w[i]   = t_w[i] >= {1'b0, d_q};
      rem_n[i]  = ge_w[i] ? diff_w[i][47:0] : t_w[i][47:0];
      quo_n[i]  = {quo_q[i][DivSteps-2:0], ge_w[i]};
    end
  end

  // magnitude scaled by 2^f; top part above the quotient window seeds the remainder
  assign num_w[0] = entry_i.ma;
  assign num_w[1] = entry_i.mb;
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      neg0[i]   = num_w[i][47];
      mag_w[i]  = neg0[i] ? 48'(-num_w[i]) : 48'(num_w[i]);
      next_w[i] = {mag_w[i], {FracBits{1'b0}}};
      hi_w[i]   = next_w[i] >> DivSteps;
      ovf0[i]   = hi_w[i] >= NExtW'($unsigned(entry_i.fz));
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    d_d     = d_q;
    hold_d  = hold_q;
    rem_d   = rem_q;
    low_d   = low_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    res_d   = res_q;
    done_d  = 1'b0;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          hold_d = entry_i;
          if (entry_i.ok) begin
            d_d   = $unsigned(entry_i.fz);
            ovf_d = ovf0;
            neg_d = neg0;
            for (int i = 0; i < 2; i++) begin
              rem_d[i] = hi_w[i][47:0];
              low_d[i] = next_w[i][DivSteps-1:0];
              quo_d[i] = '0;
            end
            cnt_d   = '0;
            state_d = ST_RUN;
          end else begin
            res_d  = '{moment_a: entry_i.ma, moment_b: entry_i.mb,
                       vertical_force: entry_i.fz, zmp_x: '0, zmp_y: '0,
                       zmp_valid: 1'b0};
            done_d = 1'b1;
          end
        end
      end
      ST_RUN: begin
        for (int i = 0; i < 2; i++) begin
          rem_d[i] = rem_n[i];
          low_d[i] = {low_q[i][DivSteps-2:0], 1'b0};
          quo_d[i] = quo_n[i];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          res_d   = '{moment_a: hold_q.ma, moment_b: hold_q.mb,
                      vertical_force: hold_q.fz,
                      zmp_x: zmp_fin(quo_n[0], ovf_q[0], neg_q[0]),
                      zmp_y: zmp_fin(quo_n[1], ovf_q[1], neg_q[1]),
                      zmp_valid: 1'b1};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    hold_q <= hold_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

endmodule

// ===== rtl/core/zmp_from_four_load_cells_top.sv =====
// ---------------------------------------------------------------------------
// zmp_from_four_load_cells_top: zero moment point of one foot
// four load cell readings in, two moments, vertical force and zmp out
// ---------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low; its result
// appears on result_o for exactly one cycle with done_o high, and there is no
// way to hold it off, so capture it on that cycle. Results come out in input
// order, one per item. The front takes a new item every cycle while the
// four-entry queue has room (busy covers the queue plus the two scaling
// stages), so short bursts go in back to back. The back divides both moments
// by the force in two lanes side by side, one quotient bit per cycle over 34
// bits, so a valid item (force at least 1.0) holds the back, which takes no
// new item until the division ends; an item with force below 1.0 skips the
// divider. An item passes the two scaling stages, the queue and the back,
// which registers the result. Registers sit at byte addresses 0, 4, 8 and
// 12; the user must write them only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module zmp_from_four_load_cells_top import zmp4_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input beat
  input  logic             start,
  output logic             busy,
  input  load_t            load_i,
  // result beat
  output logic             done_o,
  output result_t          result_o
);

  cfg_t    cfg;
  q_stat_t q_stat;
  logic    push, pop;
  entry_t  wr_entry, rd_entry;

  // gains and reverse flag
  zmp4_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // scaling, saturation and force check, pipelined
  zmp4_front #(.FracBits(FracBits)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .load_i   (load_i),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (wr_entry)
  );

  // decouples the front, one item per cycle while not busy, from the iterative back
  zmp4_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .stat_o  (q_stat)
  );

  // two-lane serial divider and result register
  zmp4_back #(.FracBits(FracBits)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .entry_i  (rd_entry),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ===== rtl/core/zmp4_checker.sv =====
// ---------------------------------------------------------------------------
// zmp4_checker: port level checks
// result consistency and beat bookkeeping seen from the top level ports
// ---------------------------------------------------------------------------
module zmp4_checker import zmp4_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    pready,
  input logic    done_o,
  input result_t result_o
);

  localparam logic [47:0] OneVal = 48'(1) << FracBits;

  logic [7:0] outstanding_q;
  logic       force_ok;

  assign force_ok = !result_o.vertical_force[47] &&
                    ($unsigned(result_o.vertical_force) >= OneVal);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + {7'd0, start && !busy} - {7'd0, done_o};
    end
  end

  // no result beat without an accepted item still owed
  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> outstanding_q != '0)
    else $error("result beat without an outstanding item");

  // valid flag follows the force threshold
  a_valid_vs_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.zmp_valid == force_ok))
    else $error("zmp_valid disagrees with vertical_force");

  // an invalid point is zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.zmp_valid |-> result_o.zmp_x == '0 && result_o.zmp_y == '0)
    else $error("invalid zmp not zeroed");

  // an item cannot finish in the cycle after its accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && outstanding_q == '0 |=> !done_o)
    else $error("result beat too early");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind zmp_from_four_load_cells_top zmp4_checker #(.FracBits(FracBits)) u_zmp4_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .pready   (pready),
  .done_o   (done_o),
  .result_o (result_o)
);
